// ===== hdl/nfws_pkg.sv =====
// shared constants, codes and types for the nor flash write sequencer
`default_nettype none

package nfws_pkg;

  localparam int FLASH_BYTES  = 2097152;
  localparam int SECTOR_BYTES = 4096;
  localparam int PAGE_BYTES   = 256;

  localparam int ADDR_W     = 24;
  localparam int LEN_W      = 16;
  localparam int REM_W      = LEN_W + 1;
  localparam int SEC_W      = $clog2(SECTOR_BYTES);
  localparam int PG_W       = $clog2(PAGE_BYTES);
  localparam int CNT_W      = SEC_W + 1;
  localparam int PAGES      = SECTOR_BYTES / PAGE_BYTES;
  localparam int PAGE_IDX_W = SEC_W - PG_W;
  localparam int CUR_W      = PAGE_IDX_W + 1;
  localparam int CHK_W      = ADDR_W + 1;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_SECTOR = 3'd1,
    OP_SOURCE = 3'd2,
    OP_DONE   = 3'd3,
    OP_BUF    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_READ     = 3'd1,
    CMD_ERASE    = 3'd2,
    CMD_PROGRAM  = 3'd3,
    CMD_FINISHED = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_READ    = 3'd1,
    PH_SOURCE  = 3'd2,
    PH_PARTIAL = 3'd3,
    PH_ERASE   = 3'd4,
    PH_FULL    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_HW      = 2'd3
  } status_t;

  localparam logic [1:0] DONE_OK      = 2'd0;
  localparam logic [1:0] DONE_TIMEOUT = 2'd1;

  typedef struct packed {
    logic             we;
    logic [SEC_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [SEC_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hdl/nfws_store.sv =====
// sector store: single-port-write ram with registered read and write-to-read bypass
`default_nettype none

module nfws_store
  import nfws_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output logic [7:0]    rdata
);

  logic [7:0] mem [SECTOR_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      if (req.we && (req.waddr == req.raddr)) begin
        rdata_r <= req.wdata;
      end else begin
        rdata_r <= mem[req.raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/nor_flash_write_sequencer.sv =====
// top level: read-modify-write sequencer for serial nor flash sector writes
//
// input beats carry an operation in in_tuser and its arguments in in_tdata.
// a start beat is checked and split into sector chunks; each chunk issues a
// sector read, takes the returned sector bytes and then the new source bytes,
// and goes on to partial page programs, or to a sector erase and full programs
// of the dirty pages. command done beats step the sequence, and a failed one
// ends the request with its status. buffer read beats return a store byte.
// result beats carry the command in out_tuser and its fields in out_tdata.
// throughput: one input beat per cycle while results are taken; the store is read
// in the cycle a beat is accepted and the beat is worked in the working stage, with a
// write-to-read bypass in the store so back-to-back source bytes and buffer reads
// see the latest data. a beat passes the working stage and the output register.
// a stalled result holds in the output register; one more beat waits in the
// working stage, and in_tready drops until the result is taken.
// reset returns the sequence to idle with no request open; the store keeps
// whatever it held and is only meaningful where written by sector and source bytes.
`default_nettype none

module nor_flash_write_sequencer
  import nfws_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // address, length, data_byte, done_status, buffer_index
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  wire logic [2:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // flash_address, byte_count, buffer_offset, status, data_out
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // command
  output logic [2:0]                 out_tuser
);

  function automatic logic [CNT_W-1:0] partial_count(input logic [SEC_W-1:0] offs,
                                                     input logic [CNT_W-1:0] cbytes,
                                                     input logic [CNT_W-1:0] pos);
    logic [PG_W-1:0]  in_page;
    logic [CNT_W-1:0] room;
    logic [CNT_W-1:0] rest;
    in_page = offs[PG_W-1:0] + pos[PG_W-1:0];
    room    = CNT_W'(PAGE_BYTES) - CNT_W'(in_page);
    rest    = cbytes - pos;
    return (room < rest) ? room : rest;
  endfunction

  // sequencer state
  phase_t            phase_r, phase_nxt;
  logic [ADDR_W-1:0] next_address_r, next_address_nxt;
  logic [REM_W-1:0]  remaining_r, remaining_nxt;
  logic [SEC_W-1:0]  chunk_offset_r, chunk_offset_nxt;
  logic [CNT_W-1:0]  chunk_bytes_r, chunk_bytes_nxt;
  logic [CNT_W-1:0]  byte_counter_r, byte_counter_nxt;
  logic [CUR_W-1:0]  page_cursor_r, page_cursor_nxt;
  logic [PAGES-1:0]  dirty_r, dirty_nxt;
  logic              erase_r, erase_nxt;

  // working stage
  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic [7:0]        s1_data_r;
  logic [1:0]        s1_done_r;

  // output register
  logic              out_valid_r;
  cmd_t              out_cmd_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [CNT_W-1:0]  out_count_r;
  logic [SEC_W-1:0]  out_offset_r;
  status_t           out_status_r;
  logic [7:0]        out_data_r;

  // input beat fields
  op_t               in_op;
  logic [ADDR_W-1:0] in_address;
  logic [LEN_W-1:0]  in_length;
  logic [7:0]        in_data_byte;
  logic [1:0]        in_done_status;
  logic [SEC_W-1:0]  in_buffer_index;

  logic              in_fire;
  logic              s1_fire;
  mem_req_t          mreq;
  logic [7:0]        mem_rdata;

  // result of the working stage
  logic              res_valid;
  cmd_t              res_cmd;
  logic [ADDR_W-1:0] res_addr;
  logic [CNT_W-1:0]  res_count;
  logic [SEC_W-1:0]  res_offset;
  status_t           res_status;
  logic [7:0]        res_data;

  // follow-on actions
  logic              do_start, do_finish, do_partial, do_scan;
  logic [ADDR_W-1:0] na;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  part_pos;
  logic [CUR_W-1:0]  scan_from;
  logic              scan_found;
  logic [PAGE_IDX_W-1:0] scan_hit;
  logic [ADDR_W-1:0] sector_base;
  logic [SEC_W-1:0]  src_idx;
  logic [CNT_W-1:0]  bc_inc;
  logic [CNT_W-1:0]  room;
  logic [SEC_W-1:0]  part_off;
  logic [CHK_W-1:0]  req_end;

  assign in_op           = op_t'(in_tuser);
  assign in_address      = in_tdata[23:0];
  assign in_length       = in_tdata[39:24];
  assign in_data_byte    = in_tdata[47:40];
  assign in_done_status  = in_tdata[49:48];
  assign in_buffer_index = in_tdata[61:50];

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign sector_base = next_address_r - ADDR_W'(chunk_offset_r);
  assign src_idx     = chunk_offset_r + byte_counter_r[SEC_W-1:0];
  assign req_end     = CHK_W'(s1_addr_r) + CHK_W'(s1_len_r);

  always_comb begin
    phase_nxt        = phase_r;
    next_address_nxt = next_address_r;
    remaining_nxt    = remaining_r;
    chunk_offset_nxt = chunk_offset_r;
    chunk_bytes_nxt  = chunk_bytes_r;
    byte_counter_nxt = byte_counter_r;
    page_cursor_nxt  = page_cursor_r;
    dirty_nxt        = dirty_r;
    erase_nxt        = erase_r;
    res_valid  = 1'b0;
    res_cmd    = CMD_NONE;
    res_addr   = '0;
    res_count  = '0;
    res_offset = '0;
    res_status = ST_OK;
    res_data   = '0;
    do_start   = 1'b0;
    do_finish  = 1'b0;
    do_partial = 1'b0;
    do_scan    = 1'b0;
    na         = next_address_r;
    rem        = remaining_r;
    part_pos   = '0;
    scan_from  = '0;
    scan_found = 1'b0;
    scan_hit   = '0;
    bc_inc     = '0;
    room       = '0;
    part_off   = '0;
    mreq.we    = 1'b0;
    mreq.waddr = '0;
    mreq.wdata = '0;

    if (s1_fire) begin
      unique case (s1_op_r)
        OP_START: begin
          if (phase_r == PH_IDLE) begin
            if ((s1_len_r == '0) || (req_end > CHK_W'(FLASH_BYTES))) begin
              res_valid  = 1'b1;
              res_cmd    = CMD_FINISHED;
              res_status = ST_INVALID;
            end else begin
              na       = s1_addr_r;
              rem      = REM_W'(s1_len_r);
              do_start = 1'b1;
            end
          end
        end
        OP_SECTOR: begin
          if ((phase_r == PH_READ) && (byte_counter_r < CNT_W'(SECTOR_BYTES))) begin
            mreq.we          = 1'b1;
            mreq.waddr       = byte_counter_r[SEC_W-1:0];
            mreq.wdata       = s1_data_r;
            byte_counter_nxt = byte_counter_r + 1'b1;
          end
        end
        OP_SOURCE: begin
          if ((phase_r == PH_SOURCE) && (byte_counter_r < chunk_bytes_r)) begin
            if ((mem_rdata & s1_data_r) != s1_data_r) begin
              erase_nxt = 1'b1;
            end
            mreq.we    = 1'b1;
            mreq.waddr = src_idx;
            mreq.wdata = s1_data_r;
            dirty_nxt[src_idx[SEC_W-1:PG_W]] = 1'b1;
            bc_inc = byte_counter_r + 1'b1;
            if (bc_inc < chunk_bytes_r) begin
              byte_counter_nxt = bc_inc;
            end else begin
              byte_counter_nxt = '0;
              if (erase_nxt) begin
                phase_nxt = PH_ERASE;
                res_valid = 1'b1;
                res_cmd   = CMD_ERASE;
                res_addr  = sector_base;
              end else begin
                do_partial = 1'b1;
                part_pos   = '0;
              end
            end
          end
        end
        OP_DONE: begin
          if ((phase_r != PH_IDLE) && (phase_r != PH_SOURCE)) begin
            if (s1_done_r != DONE_OK) begin
              phase_nxt  = PH_IDLE;
              res_valid  = 1'b1;
              res_cmd    = CMD_FINISHED;
              res_status = (s1_done_r == DONE_TIMEOUT) ? ST_TIMEOUT : ST_HW;
            end else begin
              priority case (phase_r)
                PH_READ: begin
                  byte_counter_nxt = '0;
                  phase_nxt        = PH_SOURCE;
                end
                PH_PARTIAL: begin
                  bc_inc = byte_counter_r
                         + partial_count(chunk_offset_r, chunk_bytes_r, byte_counter_r);
                  if (bc_inc >= chunk_bytes_r) begin
                    do_finish = 1'b1;
                  end else begin
                    byte_counter_nxt = bc_inc;
                    do_partial       = 1'b1;
                    part_pos         = bc_inc;
                  end
                end
                PH_ERASE: begin
                  do_scan   = 1'b1;
                  scan_from = '0;
                end
                default: begin
                  do_scan   = 1'b1;
                  scan_from = page_cursor_r + 1'b1;
                end
              endcase
            end
          end
        end
        OP_BUF: begin
          res_valid = 1'b1;
          res_cmd   = CMD_NONE;
          res_data  = mem_rdata;
        end
        default: begin
        end
      endcase
    end

    if (do_scan) begin
      for (int i = PAGES - 1; i >= 0; i--) begin
        if (dirty_r[i] && (CUR_W'(i) >= scan_from)) begin
          scan_found = 1'b1;
          scan_hit   = PAGE_IDX_W'(i);
        end
      end
      if (scan_found) begin
        page_cursor_nxt = CUR_W'(scan_hit);
        phase_nxt       = PH_FULL;
        res_valid       = 1'b1;
        res_cmd         = CMD_PROGRAM;
        res_addr        = sector_base + ADDR_W'({scan_hit, {PG_W{1'b0}}});
        res_count       = CNT_W'(PAGE_BYTES);
        res_offset      = {scan_hit, {PG_W{1'b0}}};
      end else begin
        do_finish = 1'b1;
      end
    end

    if (do_finish) begin
      na               = next_address_r + ADDR_W'(chunk_bytes_r);
      rem              = remaining_r - REM_W'(chunk_bytes_r);
      next_address_nxt = na;
      remaining_nxt    = rem;
      if (rem == '0) begin
        phase_nxt = PH_IDLE;
        res_valid = 1'b1;
        res_cmd   = CMD_FINISHED;
      end else begin
        do_start = 1'b1;
      end
    end

    if (do_start) begin
      room             = CNT_W'(SECTOR_BYTES) - CNT_W'(na[SEC_W-1:0]);
      next_address_nxt = na;
      remaining_nxt    = rem;
      chunk_offset_nxt = na[SEC_W-1:0];
      chunk_bytes_nxt  = (REM_W'(room) < rem) ? room : rem[CNT_W-1:0];
      dirty_nxt        = '0;
      erase_nxt        = 1'b0;
      byte_counter_nxt = '0;
      page_cursor_nxt  = '0;
      phase_nxt        = PH_READ;
      res_valid        = 1'b1;
      res_cmd          = CMD_READ;
      res_addr         = na - ADDR_W'(na[SEC_W-1:0]);
      res_count        = CNT_W'(SECTOR_BYTES);
    end

    if (do_partial) begin
      part_off   = chunk_offset_r + part_pos[SEC_W-1:0];
      phase_nxt  = PH_PARTIAL;
      res_valid  = 1'b1;
      res_cmd    = CMD_PROGRAM;
      res_addr   = sector_base + ADDR_W'(part_off);
      res_count  = partial_count(chunk_offset_r, chunk_bytes_r, part_pos);
      res_offset = part_off;
    end
  end

  // read issue for the beat being accepted, using the state it will see
  always_comb begin
    mreq.re    = 1'b0;
    mreq.raddr = '0;
    if (in_fire) begin
      if (in_op == OP_SOURCE) begin
        mreq.re    = 1'b1;
        mreq.raddr = chunk_offset_nxt + byte_counter_nxt[SEC_W-1:0];
      end else if (in_op == OP_BUF) begin
        mreq.re    = 1'b1;
        mreq.raddr = in_buffer_index;
      end
    end
  end

  nfws_store u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      next_address_r <= '0;
      remaining_r    <= '0;
      chunk_offset_r <= '0;
      chunk_bytes_r  <= '0;
      byte_counter_r <= '0;
      page_cursor_r  <= '0;
      dirty_r        <= '0;
      erase_r        <= 1'b0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      next_address_r <= next_address_nxt;
      remaining_r    <= remaining_nxt;
      chunk_offset_r <= chunk_offset_nxt;
      chunk_bytes_r  <= chunk_bytes_nxt;
      byte_counter_r <= byte_counter_nxt;
      page_cursor_r  <= page_cursor_nxt;
      dirty_r        <= dirty_nxt;
      erase_r        <= erase_nxt;
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_fire) begin
        out_valid_r <= res_valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_op;
      s1_addr_r <= in_address;
      s1_len_r  <= in_length;
      s1_data_r <= in_data_byte;
      s1_done_r <= in_done_status;
    end
    if (s1_fire && res_valid) begin
      out_cmd_r    <= res_cmd;
      out_addr_r   <= res_addr;
      out_count_r  <= res_count;
      out_offset_r <= res_offset;
      out_status_r <= res_status;
      out_data_r   <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_cmd_r;
  assign out_tdata  = {5'd0, out_data_r, out_status_r, out_offset_r, out_count_r, out_addr_r};

endmodule

`default_nettype wire
